### design/itfhg_pkg.sv
// ----------------------------------------------------------------------------
// itfhg_pkg
// Shared types and constants for the IPv4 tunnel fragment header generator.
// ----------------------------------------------------------------------------
`default_nettype none

package itfhg_pkg;

  // Outer header constants
  localparam logic [15:0] VER_IHL_TOS  = 16'h4500;
  localparam logic [7:0]  TTL_VALUE    = 8'd128;
  localparam logic [15:0] HDR_BYTES    = 16'd20;
  localparam logic [15:0] FLAG_DF      = 16'h4000;
  localparam logic [15:0] FLAG_MF      = 16'h2000;
  localparam logic [15:0] MF_CLEAR     = 16'hDFFF;
  localparam int          UNIT_SHIFT   = 3;   // 8-byte offset units
  localparam logic [10:0] MTU_MIN      = 11'd1044;
  localparam logic [10:0] MTU_MAX      = 11'd1500;
  localparam logic [10:0] MTU_RESET    = 11'd1500;
  localparam int          MAX_FRAG_LOG = 6;   // at most 64 fragments

  // Widths
  localparam int SUM_W  = 20;  // ten 16-bit words fit in 20 bits
  localparam int IDX_W  = 2;
  localparam int CFG_W  = 32;
  localparam int IN_W   = 48;
  localparam int OUT_W  = 64;

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_SRC_ADDR = 2'd0,
    REG_DST_ADDR = 2'd1,
    REG_MTU      = 2'd2
  } reg_idx_t;

  // Base-sum word steps (identification, ttl/proto, src hi/lo, dst hi/lo)
  localparam logic [2:0] BASE_LAST = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE,
    ST_DECIDE,
    ST_SETUP,
    ST_SUM_TOT,
    ST_SUM_FLG,
    ST_FOLD1,
    ST_FOLD2,
    ST_OUT
  } state_t;

endpackage : itfhg_pkg

`default_nettype wire

### design/ipv4_tunnel_fragment_header_gen.sv
// ----------------------------------------------------------------------------
// ipv4_tunnel_fragment_header_gen
// Builds the outer IPv4 tunnel header(s) for one inner-packet descriptor.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one descriptor per transfer. m_axis returns one outer
//   header per transfer; m_axis_tlast marks the final header of a packet.
//   The cfg port writes source address, destination address and MTU; the user
//   must do so only while the block is idle, which the block does not enforce.
// Sequencing:
//   After a descriptor transfer, the base steps build the constant part of the
//   header sum (identification, ttl/proto, source and destination halves) in
//   the shared 20-bit adder; a decide step picks single header, fragments or drop.
//   Each fragment header then passes setup, add total length, add flags and
//   two end-around folds; a single header skips setup. That adder is the limit.
//   The header is held on m_axis until taken; the next fragment's setup follows
//   that transfer. s_axis_tready is high only when no descriptor is in work.
// Reset:
//   rst clears the sequencer and restores the registers to 0, 0 and 1500.
// Back-pressure:
//   A stalled m_axis simply holds the current header; nothing is lost.
// Oversized packets (more than 64 fragments, DF clear) produce no header at all.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_tunnel_fragment_header_gen (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // tdata: payload_length[15:0], protocol_number[23:16], packet_ident[39:24],
  //        dont_fragment[40], zero pad[47:41]
  input  wire logic [itfhg_pkg::IN_W-1:0]  s_axis_tdata,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: total_length[15:0], flags_offset[31:16], header_checksum[47:32],
  //        payload_offset[63:48]
  output logic [itfhg_pkg::OUT_W-1:0]    m_axis_tdata,
  output logic                           m_axis_tlast,   // last_header
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  input  wire logic                      cfg_wr_en,
  input  wire logic [itfhg_pkg::IDX_W-1:0] cfg_addr,
  input  wire logic [itfhg_pkg::CFG_W-1:0] cfg_wdata
);
  import itfhg_pkg::*;

  // Configuration registers
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [10:0] mtu;

  // Sequencer
  state_t state, state_next;
  logic [2:0] step;

  // Descriptor
  logic [15:0] len;
  logic [7:0]  proto;
  logic [15:0] ident;
  logic        df;

  // Per-header datapath
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] base;
  logic [15:0]      rem;    // payload bytes not yet covered
  logic [15:0]      poff;
  logic [15:0]      tot;
  logic [15:0]      flags;
  logic             last;

  // Derived configuration
  logic [10:0] mtu_eff;
  logic [10:0] each;
  logic [16:0] len_hdr;
  logic        single;
  logic        too_many;
  logic        rem_last;

  // Shared adder
  logic [SUM_W-1:0] add_a;
  logic [SUM_W-1:0] add_b;
  logic [SUM_W-1:0] add_sum;

  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_comb begin
    if (mtu < MTU_MIN) begin
      mtu_eff = MTU_MIN;
    end else if (mtu > MTU_MAX) begin
      mtu_eff = MTU_MAX;
    end else begin
      mtu_eff = mtu;
    end
  end

  // Fragment payload: (effective mtu - 20) rounded down to 8 bytes
  assign each     = (mtu_eff - HDR_BYTES[10:0]) & ~11'd7;
  assign len_hdr  = {1'b0, len} + {1'b0, HDR_BYTES};
  assign single   = df || (len_hdr <= {6'd0, mtu_eff});
  assign too_many = {1'b0, len} > ({6'd0, each} << MAX_FRAG_LOG);
  assign rem_last = rem <= {5'd0, each};

  // Operand select for the shared adder
  always_comb begin
    add_a = acc;
    add_b = '0;
    unique case (state)
      ST_BASE: begin
        unique case (step)
          3'd0:    add_b = {4'd0, ident};
          3'd1:    add_b = {4'd0, TTL_VALUE, proto};
          3'd2:    add_b = {4'd0, src_addr[31:16]};
          3'd3:    add_b = {4'd0, src_addr[15:0]};
          3'd4:    add_b = {4'd0, dst_addr[31:16]};
          default: add_b = {4'd0, dst_addr[15:0]};
        endcase
      end
      ST_SUM_TOT: begin
        add_a = base;
        add_b = {4'd0, tot};
      end
      ST_SUM_FLG: add_b = {4'd0, flags};
      ST_FOLD1, ST_FOLD2: begin
        add_a = {4'd0, acc[15:0]};
        add_b = {16'd0, acc[SUM_W-1:16]};
      end
      default: ;
    endcase
  end

  assign add_sum = add_a + add_b;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_xfer) state_next = ST_BASE;
      ST_BASE:    if (step == BASE_LAST) state_next = ST_DECIDE;
      ST_DECIDE: begin
        priority if (single) begin
          state_next = ST_SUM_TOT;
        end else if (too_many) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP:   state_next = ST_SUM_TOT;
      ST_SUM_TOT: state_next = ST_SUM_FLG;
      ST_SUM_FLG: state_next = ST_FOLD1;
      ST_FOLD1:   state_next = ST_FOLD2;
      ST_FOLD2:   state_next = ST_OUT;
      ST_OUT: begin
        if (out_xfer) begin
          state_next = last ? ST_IDLE : ST_SETUP;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      src_addr <= '0;
      dst_addr <= '0;
      mtu      <= MTU_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_SRC_ADDR: src_addr <= cfg_wdata;
        REG_DST_ADDR: dst_addr <= cfg_wdata;
        REG_MTU:      mtu      <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // Step counter for the base sum
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (state == ST_BASE) begin
      step <= step + 3'd1;
    end else begin
      step <= '0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          len   <= s_axis_tdata[15:0];
          proto <= s_axis_tdata[23:16];
          ident <= s_axis_tdata[39:24];
          df    <= s_axis_tdata[40];
          acc   <= {4'd0, VER_IHL_TOS};
        end
      end
      ST_BASE: acc <= add_sum;
      ST_DECIDE: begin
        base <= acc;
        rem  <= len;
        poff <= '0;
        // single header: saturate total length, DF on request
        tot   <= len_hdr[16] ? 16'hFFFF : len_hdr[15:0];
        flags <= df ? FLAG_DF : 16'd0;
        last  <= 1'b1;
      end
      ST_SETUP: begin
        last  <= rem_last;
        tot   <= (rem_last ? rem : {5'd0, each}) + HDR_BYTES;
        flags <= rem_last ? ({3'd0, poff[15:UNIT_SHIFT]} & MF_CLEAR)
                          : ({3'd0, poff[15:UNIT_SHIFT]} | FLAG_MF);
      end
      ST_SUM_TOT, ST_SUM_FLG, ST_FOLD1, ST_FOLD2: acc <= add_sum;
      ST_OUT: begin
        if (out_xfer) begin
          poff <= poff + {5'd0, each};
          rem  <= rem - {5'd0, each};
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tlast  = last;
  assign m_axis_tdata  = {poff, ~acc[15:0], flags, tot};

`ifndef SYNTHESIS
  // one descriptor at a time: no intake while a header is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("descriptor intake while header pending");

  // the final header frees the block for the next descriptor
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("block busy after last header");

  // every header but the last carries MF
  a_mf_nonlast: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tdata[29])
    else $error("MF missing on non-final fragment");

  // after reset the block is ready
  a_reset_ready: assert property (@(posedge clk)
    rst |=> s_axis_tready)
    else $error("not ready after reset");
`endif

endmodule : ipv4_tunnel_fragment_header_gen

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IPv4 tunnel fragment header generator.
// Drives descriptors on s_axis and checks every outer header on m_axis,
// field by field, against headers predicted from the descriptor and the
// current register settings. Random idle bursts on both sides, several
// register settings including the out-of-range MTU corners.
// ----------------------------------------------------------------------------

typedef struct {
  logic [15:0] total_len;
  logic [15:0] flags_off;
  logic [15:0] csum;
  logic [15:0] pay_off;
  logic        last;
} outer_hdr_t;

// Predicts outer headers per descriptor and checks them in order.
class outer_hdr_tracker;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [10:0] mtu_reg;
  outer_hdr_t  hdrs_due[$];
  int          errors;

  function new();
    src_addr = '0;
    dst_addr = '0;
    mtu_reg  = itfhg_pkg::MTU_RESET;
    errors   = 0;
  endfunction

  function void set_reg(itfhg_pkg::reg_idx_t idx, logic [31:0] val);
    case (idx)
      itfhg_pkg::REG_SRC_ADDR: src_addr = val;
      itfhg_pkg::REG_DST_ADDR: dst_addr = val;
      itfhg_pkg::REG_MTU:      mtu_reg  = val[10:0];
      default: ;
    endcase
  endfunction

  function int unsigned eff_mtu();
    if (mtu_reg < itfhg_pkg::MTU_MIN) return itfhg_pkg::MTU_MIN;
    if (mtu_reg > itfhg_pkg::MTU_MAX) return itfhg_pkg::MTU_MAX;
    return mtu_reg;
  endfunction

  // payload bytes in every non-last fragment
  function int unsigned chunk_bytes();
    return (eff_mtu() - itfhg_pkg::HDR_BYTES) & ~32'd7;
  endfunction

  function logic [15:0] hdr_checksum(logic [15:0] tot, logic [15:0] ident,
                                     logic [15:0] flg, logic [7:0] proto);
    logic [itfhg_pkg::SUM_W-1:0] acc;
    acc = itfhg_pkg::VER_IHL_TOS + tot + ident + flg
        + {itfhg_pkg::TTL_VALUE, proto}
        + src_addr[31:16] + src_addr[15:0]
        + dst_addr[31:16] + dst_addr[15:0];
    acc = acc[15:0] + acc[itfhg_pkg::SUM_W-1:16];
    acc = acc[15:0] + acc[itfhg_pkg::SUM_W-1:16];
    return ~acc[15:0];
  endfunction

  function void push_hdr(int unsigned tot, logic [15:0] flg, logic [15:0] ident,
                         logic [7:0] proto, int unsigned poff, logic last);
    outer_hdr_t h;
    h.total_len = tot[15:0];
    h.flags_off = flg;
    h.csum      = hdr_checksum(tot[15:0], ident, flg, proto);
    h.pay_off   = poff[15:0];
    h.last      = last;
    hdrs_due.push_back(h);
  endfunction

  function void note_descriptor(logic [15:0] len, logic [7:0] proto,
                                logic [15:0] ident, logic df);
    int unsigned mtu_now, chunk, nfrag, off, tot, len_i;
    logic [15:0] flg;
    mtu_now = eff_mtu();
    len_i   = len;
    if (df || len_i + itfhg_pkg::HDR_BYTES <= mtu_now) begin
      // single header; DF one saturates at 16 bits
      tot = len_i + itfhg_pkg::HDR_BYTES;
      if (tot > 32'hFFFF) tot = 32'hFFFF;
      push_hdr(tot, df ? itfhg_pkg::FLAG_DF : 16'h0000, ident, proto, 0, 1'b1);
      return;
    end
    chunk = chunk_bytes();
    nfrag = (len_i + chunk - 1) / chunk;
    // too many fragments: dropped silently (not reachable with 16-bit lengths)
    if (nfrag > (1 << itfhg_pkg::MAX_FRAG_LOG)) return;
    for (int unsigned i = 0; i < nfrag; i++) begin
      off = i * chunk;
      flg = 16'((off >> itfhg_pkg::UNIT_SHIFT) & 32'h1FFF) | itfhg_pkg::FLAG_MF;
      tot = chunk + itfhg_pkg::HDR_BYTES;
      if (i + 1 == nfrag) begin
        flg = flg & itfhg_pkg::MF_CLEAR;
        tot = (len_i - off) + itfhg_pkg::HDR_BYTES;   // exact fit keeps full size
      end
      push_hdr(tot, flg, ident, proto, off, i + 1 == nfrag);
    end
  endfunction

  task report(string msg);
    if (errors < 40) $display("[%0t] MISMATCH %s", $time, msg);
    errors++;
  endtask

  task check_header(logic [63:0] data, logic last);
    outer_hdr_t want;
    if (hdrs_due.size() == 0) begin
      report($sformatf("header with nothing expected: %h last %b", data, last));
      return;
    end
    want = hdrs_due.pop_front();
    if (data[15:0] !== want.total_len)
      report($sformatf("total_length %h, want %h", data[15:0], want.total_len));
    if (data[31:16] !== want.flags_off)
      report($sformatf("flags_offset %h, want %h", data[31:16], want.flags_off));
    if (data[47:32] !== want.csum)
      report($sformatf("header_checksum %h, want %h", data[47:32], want.csum));
    if (data[63:48] !== want.pay_off)
      report($sformatf("payload_offset %h, want %h", data[63:48], want.pay_off));
    if (last !== want.last)
      report($sformatf("last_header %b, want %b", last, want.last));
  endtask
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import itfhg_pkg::*;

  localparam int LIMIT_CYCLES  = 1_000_000;
  // margin for the block to go back to idle after its final header
  localparam int SETTLE_CYCLES = 20;
  localparam int RAND_PHASES   = 5;
  localparam int PHASE_ITEMS   = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // descriptor side
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // header side
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // register port
  logic             cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_addr  = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // last phase runs without any idling on either side
  bit quiet = 1'b0;
  int cycle_count = 0;
  int stall_left  = 0;

  outer_hdr_tracker tracker = new();

  ipv4_tunnel_fragment_header_gen dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // header receiver: random stall bursts, changed on the falling edge
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready = 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left    = $urandom_range(0, 2);
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // every accepted header transfer goes to the checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      tracker.check_header(m_axis_tdata, m_axis_tlast);
  end

  // One descriptor transfer, optionally preceded by an idle burst.
  // tvalid stays high afterwards; the next call or the settle task moves it.
  task automatic send_descriptor(logic [15:0] len, logic [7:0] proto,
                                 logic [15:0] ident, logic df);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    // fields from bit 0 up: length, protocol, ident, DF, zero pad
    s_axis_tdata  = {7'd0, df, ident, proto, len};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_descriptor(len, proto, ident, df);
  endtask

  task automatic send_rand_id(logic [15:0] len, logic df);
    send_descriptor(len, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                    df);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Stop sending, wait for every predicted header, then let the block go idle.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (tracker.hdrs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly short packets, some multi-fragment ones, a few right at a
  // fragment boundary, and a share across the whole 16-bit range.
  function automatic logic [15:0] pick_length();
    int unsigned chunk, n, v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 1600);
      4, 5, 6:    v = $urandom_range(1601, 8000);
      7: begin
        chunk = tracker.chunk_bytes();
        n     = $urandom_range(1, 8);
        v     = n * chunk + $urandom_range(0, 2) - 1;
      end
      default:    v = $urandom_range(0, 65535);
    endcase
    return v[15:0];
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // MTU corners include values below, above and off the 8-byte grid
  function automatic logic [31:0] pick_mtu();
    case ($urandom_range(0, 7))
      0:       return 32'd1044;
      1:       return 32'd1500;
      2:       return 32'd0;
      3:       return 32'd2047;
      4:       return 32'd1043;
      5:       return 32'd1501;
      6:       return $urandom_range(1044, 1500);
      default: return $urandom_range(0, 2047);
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed, reset settings: addresses 0, MTU 1500 ---
    send_descriptor(16'd0, 8'h00, 16'h0000, 1'b0);   // empty payload
    send_descriptor(16'd0, 8'hFF, 16'hFFFF, 1'b1);   // empty, DF set
    send_rand_id(16'd1480, 1'b0);                    // fits the MTU exactly
    send_rand_id(16'd1481, 1'b0);                    // one byte over: 2 frags
    send_rand_id(16'd2960, 1'b0);                    // exactly divisible
    send_rand_id(16'd65535, 1'b1);                   // DF, total saturates
    send_rand_id(16'd65515, 1'b1);                   // DF, total hits 65535
    send_rand_id(16'd65535, 1'b0);                   // largest fragmented
    settle();

    // smallest MTU, all-ones addresses: 64 fragments for the largest length
    write_reg(REG_SRC_ADDR, 32'hFFFF_FFFF);
    write_reg(REG_DST_ADDR, 32'hFFFF_FFFF);
    write_reg(REG_MTU, 32'd1044);
    send_rand_id(16'd65535, 1'b0);
    send_rand_id(16'd1024, 1'b0);
    send_rand_id(16'd1025, 1'b0);
    send_rand_id(16'd4096, 1'b0);
    settle();

    // MTU below range clamps up
    write_reg(REG_MTU, 32'd0);
    send_rand_id(16'd2000, 1'b0);
    settle();

    // MTU above range clamps down
    write_reg(REG_MTU, 32'd2047);
    send_rand_id(16'd3000, 1'b0);
    send_rand_id(16'd1481, 1'b0);
    settle();

    // MTU off the 8-byte grid: fragment payload rounds down to 1280
    write_reg(REG_SRC_ADDR, 32'h0A00_0001);
    write_reg(REG_MTU, 32'd1303);
    send_rand_id(16'd1283, 1'b0);
    send_rand_id(16'd2561, 1'b0);
    send_rand_id(16'd2560, 1'b0);
    settle();

    // --- random phases, fresh settings each time ---
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1) quiet = 1'b1;
      write_reg(REG_SRC_ADDR, pick_addr());
      write_reg(REG_DST_ADDR, pick_addr());
      write_reg(REG_MTU, pick_mtu());
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_rand_id(pick_length(), $urandom_range(0, 3) == 0);
      settle();
    end

    if (tracker.hdrs_due.size() != 0)
      tracker.report($sformatf("%0d headers never arrived", tracker.hdrs_due.size()));

    if (tracker.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
design/itfhg_pkg.sv
design/ipv4_tunnel_fragment_header_gen.sv
tb/tb_top.sv
